@@ rtl/hfid_pkg.sv @@
package hfid_pkg;

    // Pipeline shape.
    localparam int NSTG       = 10;
    localparam int MIX_STAGES = 4;
    localparam int MIX_FIRST  = 2;

    // Stream and configuration widths.
    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [MIX_STAGES-1:0] t_mix_en;
    typedef logic [3:0]            t_action;
    typedef logic [3:0]            t_mbit;
    typedef logic [CFG_IDX_W-1:0]  t_reg_idx;

    // Fault type selector codes.
    localparam t_action ACT_DROP        = 4'd0;
    localparam t_action ACT_SPLIT_DATA  = 4'd1;
    localparam t_action ACT_SPLIT_CTL   = 4'd2;
    localparam t_action ACT_SPLIT_BIDI  = 4'd3;
    localparam t_action ACT_MUTATE_CTL  = 4'd4;
    localparam t_action ACT_MUTATE_DATA = 4'd5;
    localparam t_action ACT_TRUNC_CTL   = 4'd6;
    localparam t_action ACT_TRUNC_DATA  = 4'd7;
    localparam t_action ACT_DELAY       = 4'd8;
    localparam t_action ACT_REORDER     = 4'd9;

    // Bit positions in the fault type mask.
    localparam t_mbit MB_DROP_CTL    = 4'd0;
    localparam t_mbit MB_DROP_DATA   = 4'd1;
    localparam t_mbit MB_DROP_RESET  = 4'd2;
    localparam t_mbit MB_DROP_STOP   = 4'd3;
    localparam t_mbit MB_SPLIT_DATA  = 4'd4;
    localparam t_mbit MB_SPLIT_CTL   = 4'd5;
    localparam t_mbit MB_SPLIT_BIDI  = 4'd6;
    localparam t_mbit MB_MUTATE_CTL  = 4'd7;
    localparam t_mbit MB_MUTATE_DATA = 4'd8;
    localparam t_mbit MB_TRUNC_CTL   = 4'd9;
    localparam t_mbit MB_TRUNC_DATA  = 4'd10;
    localparam t_mbit MB_DELAY       = 4'd11;
    localparam t_mbit MB_REORDER     = 4'd12;

    // Configuration register indexes.
    localparam t_reg_idx REG_INJECT_ENABLE     = 3'd0;
    localparam t_reg_idx REG_RATE_PER_MILLE    = 3'd1;
    localparam t_reg_idx REG_FAULT_TYPE_MASK   = 3'd2;
    localparam t_reg_idx REG_HASH_SEED         = 3'd3;
    localparam t_reg_idx REG_CODE_SEND_CONTROL = 3'd4;
    localparam t_reg_idx REG_CODE_SEND_DATA    = 3'd5;
    localparam t_reg_idx REG_CODE_RESET_DATA   = 3'd6;
    localparam t_reg_idx REG_CODE_STOP_DATA    = 3'd7;

    // Key multipliers and finalizer constants.
    localparam logic [63:0] K_STEP   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] K_INDEX  = 64'hD6E8FEB86659FD93;
    localparam logic [63:0] K_KIND1  = 64'hA0761D6478BD642F;
    localparam logic [63:0] K_KIND2  = 64'h3C79AC492BA7B653;
    localparam logic [63:0] FIN_C1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] FIN_C2   = 64'h94D049BB133111EB;
    localparam logic [63:0] DUE_SALT = 64'hD0E71AE000000001;

    // Modulo reduction: 2^16, 2^32, 2^48 taken modulo 1000 and 900.
    localparam logic [9:0] MK_W1 = 10'd536;
    localparam logic [9:0] MK_W2 = 10'd296;
    localparam logic [9:0] MK_W3 = 10'd656;
    localparam logic [9:0] MH_W1 = 10'd736;
    localparam logic [9:0] MH_W2 = 10'd796;
    localparam logic [9:0] MH_W3 = 10'd856;
    localparam int SUM_K_W  = 27;
    localparam int SUM_H_W  = 28;
    localparam int Q_K_W    = 17;
    localparam int Q_H_W    = 18;
    localparam int RCP_W    = 31;
    localparam int PROD_K_W = SUM_K_W + RCP_W;
    localparam int PROD_H_W = SUM_H_W + RCP_W;
    localparam int RCP_SHIFT = 40;
    localparam logic [RCP_W-1:0] RCP_K = 31'd1099511627;
    localparam logic [RCP_W-1:0] RCP_H = 31'd1221679586;
    localparam logic [9:0] DIV_K    = 10'd1000;
    localparam logic [9:0] DIV_H    = 10'd900;
    localparam logic [6:0] DUE_BASE = 7'd100;

    // Per-type salt; drop uses the kind code instead and gets none.
    function automatic logic [63:0] type_salt(input t_action act);
        logic [63:0] s;
        case (act)
            ACT_SPLIT_DATA:  s = 64'h3C79AC492BA7B653;
            ACT_SPLIT_CTL:   s = 64'hA1B2C3D4E5F60718;
            ACT_SPLIT_BIDI:  s = 64'hF0E1D2C3B4A59687;
            ACT_MUTATE_CTL:  s = 64'h7E57A7E000000001;
            ACT_MUTATE_DATA: s = 64'hDA7ADA7A00000001;
            ACT_TRUNC_CTL:   s = 64'h7ECCA7E000000011;
            ACT_TRUNC_DATA:  s = 64'hDA7A7ECDA7E00011;
            ACT_DELAY:       s = 64'hDE1A7DE1A7000001;
            ACT_REORDER:     s = 64'hADACE4720DEC0001;
            default:         s = 64'd0;
        endcase
        return s;
    endfunction

    // Mask bit that enables each non-drop fault type.
    function automatic t_mbit type_bit(input t_action act);
        t_mbit b;
        case (act)
            ACT_SPLIT_DATA:  b = MB_SPLIT_DATA;
            ACT_SPLIT_CTL:   b = MB_SPLIT_CTL;
            ACT_SPLIT_BIDI:  b = MB_SPLIT_BIDI;
            ACT_MUTATE_CTL:  b = MB_MUTATE_CTL;
            ACT_MUTATE_DATA: b = MB_MUTATE_DATA;
            ACT_TRUNC_CTL:   b = MB_TRUNC_CTL;
            ACT_TRUNC_DATA:  b = MB_TRUNC_DATA;
            ACT_DELAY:       b = MB_DELAY;
            ACT_REORDER:     b = MB_REORDER;
            default:         b = MB_DROP_CTL;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/hfid_mix64.sv @@
module hfid_mix64 (
    input  logic              i_clk,
    input  hfid_pkg::t_mix_en i_en,
    input  logic [63:0]       i_key,
    output logic [63:0]       o_hash
);
    import hfid_pkg::*;

    logic [63:0] n_v1;
    logic [63:0] n_a_ll;
    logic [31:0] n_a_lh;
    logic [31:0] n_a_hl;
    logic [63:0] r_a_ll;
    logic [31:0] r_a_lh;
    logic [31:0] r_a_hl;
    logic [63:0] n_w;
    logic [63:0] r_w;
    logic [63:0] n_w1;
    logic [63:0] n_b_ll;
    logic [31:0] n_b_lh;
    logic [31:0] n_b_hl;
    logic [63:0] r_b_ll;
    logic [31:0] r_b_lh;
    logic [31:0] r_b_hl;
    logic [63:0] n_z;
    logic [63:0] n_h;
    logic [63:0] r_h;

    // First xor-shift and the 32-bit partial products of the first multiply.
    always_comb begin
        n_v1   = i_key ^ (i_key >> 30);
        n_a_ll = 64'(n_v1[31:0]) * 64'(FIN_C1[31:0]);
        n_a_lh = 32'(n_v1[31:0] * FIN_C1[63:32]);
        n_a_hl = 32'(n_v1[63:32] * FIN_C1[31:0]);
    end

    // Sum of the first product, modulo 2^64.
    assign n_w = r_a_ll + {r_a_lh + r_a_hl, 32'd0};

    // Second xor-shift and partial products of the second multiply.
    always_comb begin
        n_w1   = r_w ^ (r_w >> 27);
        n_b_ll = 64'(n_w1[31:0]) * 64'(FIN_C2[31:0]);
        n_b_lh = 32'(n_w1[31:0] * FIN_C2[63:32]);
        n_b_hl = 32'(n_w1[63:32] * FIN_C2[31:0]);
    end

    // Sum of the second product and the final xor-shift.
    always_comb begin
        n_z = r_b_ll + {r_b_lh + r_b_hl, 32'd0};
        n_h = n_z ^ (n_z >> 31);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_ll <= n_a_ll;
            r_a_lh <= n_a_lh;
            r_a_hl <= n_a_hl;
        end
        if (i_en[1]) begin
            r_w <= n_w;
        end
        if (i_en[2]) begin
            r_b_ll <= n_b_ll;
            r_b_lh <= n_b_lh;
            r_b_hl <= n_b_hl;
        end
        if (i_en[3]) begin
            r_h <= n_h;
        end
    end

    assign o_hash = r_h;

endmodule

@@ rtl/hashed_fault_injection_decider.sv @@
// Requests pass through stages 0 to 9 in order. Throughput: one request per
// cycle while the output takes results; each of the ten stages moves on its own,
// so bubbles close up while the output waits and no request is lost or repeated.
// The stage count is set by the two 64-bit finalizer multiplies, each split into
// 32-bit partial products, and by the reciprocal modulo-1000/900 reduction.
// Reset (synchronous, active low) clears all valid bits and restores register defaults.
module hashed_fault_injection_decider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [hfid_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hfid_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Request stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata from bit 0: step_number[63:0], item_index[79:64], kind_a[87:80],
    // kind_b[95:88], time_now[159:96]
    input  logic [hfid_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser from bit 0: action[3:0]
    input  logic [hfid_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    // Result stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata from bit 0: fires[0], due_time[64:1], zero padding[71:65]
    output logic [hfid_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import hfid_pkg::*;

    // Configuration registers.
    logic        r_inject_enable;
    logic [9:0]  r_rate;
    logic [12:0] r_mask;
    logic [63:0] r_seed;
    logic [7:0]  r_code_ctl;
    logic [7:0]  r_code_data;
    logic [7:0]  r_code_reset;
    logic [7:0]  r_code_stop;

    // Pipeline control.
    logic [NSTG-1:0] w_adv;
    logic [NSTG-1:0] r_vld;

    // Request fields.
    t_action     w_act;
    logic [63:0] w_step;
    logic [15:0] w_idx;
    logic [7:0]  w_ka;
    logic [7:0]  w_kb;
    logic [63:0] w_now;

    // Stage 0.
    t_mbit       w_bit;
    logic        w_drop_hit;
    logic        n_elig;
    logic [63:0] n_p_ll;
    logic [31:0] n_p_lh;
    logic [31:0] n_p_hl;
    logic [47:0] n_p_il;
    logic [31:0] n_p_ih;
    logic [63:0] n_kpa;
    logic [63:0] n_kpb;
    logic [63:0] r_p_ll;
    logic [31:0] r_p_lh;
    logic [31:0] r_p_hl;
    logic [47:0] r_p_il;
    logic [31:0] r_p_ih;
    logic [63:0] r_kpa;
    logic [63:0] r_kpb;
    logic        r_use_ka;
    logic        r_use_kb;
    logic [63:0] r_salt;

    // Flags and time that ride along with each request.
    logic        r_elig_s  [NSTG-1];
    logic        r_delay_s [NSTG-1];
    logic [63:0] r_now_s   [NSTG-1];

    // Stage 1.
    logic [63:0] n_base;
    logic [63:0] r_key;
    logic [63:0] r_dkey;

    // Finalizer outputs (stage 5).
    logic [63:0] w_hash;
    logic [63:0] w_dhash;

    // Modulo stages.
    logic [SUM_K_W-1:0]  n_y_k;
    logic [SUM_H_W-1:0]  n_y_h;
    logic [SUM_K_W-1:0]  r_y_k;
    logic [SUM_H_W-1:0]  r_y_h;
    logic [PROD_K_W-1:0] n_prod_k;
    logic [PROD_H_W-1:0] n_prod_h;
    logic [Q_K_W-1:0]    r_q_k;
    logic [Q_H_W-1:0]    r_q_h;
    logic [SUM_K_W-1:0]  r_y_k7;
    logic [SUM_H_W-1:0]  r_y_h7;
    logic [10:0]         n_r_k;
    logic [10:0]         n_r_h;
    logic [10:0]         r_r_k;
    logic [10:0]         r_r_h;
    logic [9:0]          n_rc_k;
    logic [9:0]          n_rc_h;
    logic                n_fires;
    logic [63:0]         n_due;
    logic                r_fires;
    logic [63:0]         r_due;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inject_enable <= 1'b0;
            r_rate          <= 10'd0;
            r_mask          <= 13'd0;
            r_seed          <= 64'd0;
            r_code_ctl      <= 8'd0;
            r_code_data     <= 8'd1;
            r_code_reset    <= 8'd2;
            r_code_stop     <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INJECT_ENABLE:     r_inject_enable <= i_cfg_wdata[0];
                REG_RATE_PER_MILLE:    r_rate          <= i_cfg_wdata[9:0];
                REG_FAULT_TYPE_MASK:   r_mask          <= i_cfg_wdata[12:0];
                REG_HASH_SEED:         r_seed          <= i_cfg_wdata;
                REG_CODE_SEND_CONTROL: r_code_ctl      <= i_cfg_wdata[7:0];
                REG_CODE_SEND_DATA:    r_code_data     <= i_cfg_wdata[7:0];
                REG_CODE_RESET_DATA:   r_code_reset    <= i_cfg_wdata[7:0];
                REG_CODE_STOP_DATA:    r_code_stop     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_s_axis_tready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Unpack the request.
    always_comb begin
        w_act  = i_s_axis_tuser[3:0];
        w_step = i_s_axis_tdata[63:0];
        w_idx  = i_s_axis_tdata[79:64];
        w_ka   = i_s_axis_tdata[87:80];
        w_kb   = i_s_axis_tdata[95:88];
        w_now  = i_s_axis_tdata[159:96];
    end

    // Stage 0: eligibility check; drop picks its mask bit by the first matching code.
    always_comb begin
        w_drop_hit = 1'b1;
        w_bit      = type_bit(w_act);
        if (w_act == ACT_DROP) begin
            if (w_ka == r_code_ctl) begin
                w_bit = MB_DROP_CTL;
            end else if (w_ka == r_code_data) begin
                w_bit = MB_DROP_DATA;
            end else if (w_ka == r_code_reset) begin
                w_bit = MB_DROP_RESET;
            end else if (w_ka == r_code_stop) begin
                w_bit = MB_DROP_STOP;
            end else begin
                w_drop_hit = 1'b0;
            end
        end
        n_elig = r_inject_enable && (r_rate != 10'd0) && (w_act <= ACT_REORDER)
                 && w_drop_hit && r_mask[w_bit];
    end

    // Stage 0: partial products of the key multiplies.
    always_comb begin
        n_p_ll = 64'(w_step[31:0]) * 64'(K_STEP[31:0]);
        n_p_lh = 32'(w_step[31:0] * K_STEP[63:32]);
        n_p_hl = 32'(w_step[63:32] * K_STEP[31:0]);
        n_p_il = 48'(w_idx) * 48'(K_INDEX[31:0]);
        n_p_ih = 32'(w_idx * K_INDEX[63:32]);
        n_kpa  = 64'(w_ka) * K_KIND1;
        n_kpb  = 64'(w_kb) * K_KIND2;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_p_ll       <= n_p_ll;
            r_p_lh       <= n_p_lh;
            r_p_hl       <= n_p_hl;
            r_p_il       <= n_p_il;
            r_p_ih       <= n_p_ih;
            r_kpa        <= n_kpa;
            r_kpb        <= n_kpb;
            r_use_ka     <= (w_act == ACT_DROP) || (w_act == ACT_REORDER);
            r_use_kb     <= (w_act == ACT_REORDER);
            r_salt       <= type_salt(w_act);
            r_elig_s[0]  <= n_elig;
            r_delay_s[0] <= (w_act == ACT_DELAY);
            r_now_s[0]   <= w_now;
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (w_adv[k]) begin
                r_elig_s[k]  <= r_elig_s[k-1];
                r_delay_s[k] <= r_delay_s[k-1];
                r_now_s[k]   <= r_now_s[k-1];
            end
        end
    end

    // Stage 1: finish the products and form the decision key and the due-time key.
    assign n_base = r_seed
                  ^ (r_p_ll + {r_p_lh + r_p_hl, 32'd0})
                  ^ ({16'd0, r_p_il} + {r_p_ih, 32'd0});

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_key  <= n_base ^ r_salt ^ (r_use_ka ? r_kpa : 64'd0)
                      ^ (r_use_kb ? r_kpb : 64'd0);
            r_dkey <= n_base ^ DUE_SALT;
        end
    end

    // Stages 2 to 5: the two finalizers run side by side.
    hfid_mix64 u_mix_key (
        .i_clk  (i_clk),
        .i_en   (w_adv[MIX_FIRST+MIX_STAGES-1:MIX_FIRST]),
        .i_key  (r_key),
        .o_hash (w_hash)
    );

    hfid_mix64 u_mix_due (
        .i_clk  (i_clk),
        .i_en   (w_adv[MIX_FIRST+MIX_STAGES-1:MIX_FIRST]),
        .i_key  (r_dkey),
        .o_hash (w_dhash)
    );

    // Stage 6: fold the 16-bit chunks with their weights modulo 1000 and 900.
    always_comb begin
        n_y_k = SUM_K_W'(w_hash[63:48]) * SUM_K_W'(MK_W3)
              + SUM_K_W'(w_hash[47:32]) * SUM_K_W'(MK_W2)
              + SUM_K_W'(w_hash[31:16]) * SUM_K_W'(MK_W1)
              + SUM_K_W'(w_hash[15:0]);
        n_y_h = SUM_H_W'(w_dhash[63:48]) * SUM_H_W'(MH_W3)
              + SUM_H_W'(w_dhash[47:32]) * SUM_H_W'(MH_W2)
              + SUM_H_W'(w_dhash[31:16]) * SUM_H_W'(MH_W1)
              + SUM_H_W'(w_dhash[15:0]);
    end

    // Stage 7: quotient estimate by reciprocal multiply; it is low by at most one.
    always_comb begin
        n_prod_k = PROD_K_W'(r_y_k) * PROD_K_W'(RCP_K);
        n_prod_h = PROD_H_W'(r_y_h) * PROD_H_W'(RCP_H);
    end

    // Stage 8: remainder below twice the divisor.
    always_comb begin
        n_r_k = 11'(r_y_k7 - SUM_K_W'(r_q_k) * SUM_K_W'(DIV_K));
        n_r_h = 11'(r_y_h7 - SUM_H_W'(r_q_h) * SUM_H_W'(DIV_H));
    end

    // Stage 9: final correction, rate compare and due time.
    always_comb begin
        n_rc_k  = (r_r_k >= 11'(DIV_K)) ? 10'(r_r_k - 11'(DIV_K)) : r_r_k[9:0];
        n_rc_h  = (r_r_h >= 11'(DIV_H)) ? 10'(r_r_h - 11'(DIV_H)) : r_r_h[9:0];
        n_fires = r_elig_s[NSTG-2] && (n_rc_k < r_rate);
        if (n_fires && r_delay_s[NSTG-2]) begin
            n_due = r_now_s[NSTG-2] + 64'(n_rc_h) + 64'(DUE_BASE);
        end else begin
            n_due = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_y_k <= n_y_k;
            r_y_h <= n_y_h;
        end
        if (w_adv[7]) begin
            r_q_k  <= n_prod_k[RCP_SHIFT+Q_K_W-1:RCP_SHIFT];
            r_q_h  <= n_prod_h[RCP_SHIFT+Q_H_W-1:RCP_SHIFT];
            r_y_k7 <= r_y_k;
            r_y_h7 <= r_y_h;
        end
        if (w_adv[8]) begin
            r_r_k <= n_r_k;
            r_r_h <= n_r_h;
        end
        if (w_adv[9]) begin
            r_fires <= n_fires;
            r_due   <= n_due;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {(OUT_DATA_W - 65)'(0), r_due, r_fires};

endmodule

@@ rtl/hfid_chk.sv @@
module hfid_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [hfid_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import hfid_pkg::*;

    localparam int CNT_W = $clog2(NSTG + 1);

    logic             w_acc_in;
    logic             w_acc_out;
    logic [CNT_W-1:0] r_cnt;

    assign w_acc_in  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_acc_out = o_m_axis_tvalid && i_m_axis_tready;

    // Requests accepted whose results have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(w_acc_in) - CNT_W'(w_acc_out);
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // With the output side free, the pipeline must take a new request.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("request refused while the output side is free");

    // No result appears without an outstanding request.
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_cnt != '0))
        else $error("result without an outstanding request");

    // The pipeline never holds more requests than it has stages.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NSTG))
        else $error("more requests in flight than pipeline stages");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind hashed_fault_injection_decider hfid_chk u_hfid_chk (.*);
